@@ rtl/scba_pkg.sv @@
`default_nettype none
package scba_pkg;

  localparam int PAGE_COUNT = 16;
  localparam int MAX_HEAPS  = 8;
  localparam int MAX_CLASS  = 15;
  localparam int MIN_CLASS  = 3;
  localparam int NCLASS     = MAX_CLASS - MIN_CLASS + 1;
  localparam int OFF_W      = MAX_CLASS - MIN_CLASS;
  localparam int PAGE_W     = 4;
  localparam int BLK_W      = PAGE_W + OFF_W;
  localparam int LINK_DEPTH = 1 << BLK_W;
  localparam int LIST_DEPTH = MAX_HEAPS * NCLASS;
  localparam int SLOT_W     = 7;
  localparam int ADDR_W     = 19;
  localparam int HEAP_W     = 3;
  localparam int CLS_W      = 4;
  localparam int HC_W       = 4;
  localparam int STRIDE_W   = OFF_W + 1;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_TOO_LARGE = 2'd1;
  localparam logic [1:0] ST_NO_MEM    = 2'd2;
  localparam logic [1:0] ST_BAD_FREE  = 2'd3;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  localparam logic [HC_W-1:0] HC_RESET = 4'd4;

  typedef struct packed {
    logic              op;
    logic              too_large;
    logic [CLS_W-1:0]  cls;
    logic [HEAP_W-1:0] home;
    logic [ADDR_W-1:0] addr;
  } scba_req_t;

  typedef struct packed {
    logic full;
    logic empty;
  } scba_q_st_t;

  typedef enum logic [2:0] {
    B_IDLE, B_LOOK, B_HEAD_RD, B_LINK, B_CUR, B_FREE_CHK, B_FREE_RD, B_DONE
  } back_state_t;

  function automatic logic [SLOT_W-1:0] slot_of(input logic [HEAP_W-1:0] h,
                                                input logic [CLS_W-1:0] c);
    logic [SLOT_W-1:0] hx;
    hx = {4'b0, h};
    return (hx << 3) + (hx << 2) + hx + {3'b0, c} - 7'd3;
  endfunction

  function automatic logic [HC_W-1:0] hc_clamp(input logic [HC_W-1:0] v);
    logic [HC_W-1:0] r;
    r = v;
    if (v == 4'd0) r = 4'd1;
    if (v > 4'd8) r = 4'd8;
    return r;
  endfunction

endpackage
`default_nettype wire

@@ rtl/scba_ram.sv @@
`default_nettype none
module scba_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 128
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

@@ rtl/scba_front.sv @@
`default_nettype none
module scba_front (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire logic                           in_operation,
  input  wire logic [15:0]                    in_thread_key,
  input  wire logic [15:0]                    in_request_bytes,
  input  wire logic [scba_pkg::ADDR_W-1:0]    in_free_address,
  input  wire logic [scba_pkg::HC_W-1:0]      hc,
  input  wire scba_pkg::scba_q_st_t           q_st,
  output logic                                q_push,
  output scba_pkg::scba_req_t                 q_data
);

  logic                         busy_r, busy_nxt;
  logic [1:0]                   step_r, step_nxt;
  logic [15:0]                  key_r;
  logic [3:0]                   rem_r, rem_nxt;
  logic                         op_r, tl_r;
  logic [scba_pkg::CLS_W-1:0]   cls_r, cls_in;
  logic [scba_pkg::ADDR_W-1:0]  addr_r;
  logic [16:0]                  need;
  logic                         tl_in;
  logic                         accept;
  logic [7:0]                   digits;

  assign accept   = in_valid && !busy_r;
  assign in_stall = busy_r;

  // smallest class whose block holds the bytes plus header
  always_comb begin
    need   = {1'b0, in_request_bytes} + 17'd2;
    tl_in  = need > 17'd32768;
    cls_in = 4'd15;
    for (int c = 15; c >= 3; c--) begin
      if ((17'd1 << c) >= need) cls_in = 4'(c);
    end
  end

  // key mod hc, one byte a cycle, high byte first
  always_comb begin
    logic [3:0] t;
    digits  = (step_r == 2'd0) ? key_r[15:8] : key_r[7:0];
    rem_nxt = rem_r;
    for (int k = 7; k >= 0; k--) begin
      t = {rem_nxt[2:0], digits[k]};
      if (t >= hc) t = t - hc;
      rem_nxt = t;
    end
  end

  always_comb begin
    busy_nxt = busy_r;
    step_nxt = step_r;
    q_push   = 1'b0;
    if (accept) begin
      busy_nxt = 1'b1;
      step_nxt = 2'd0;
    end else if (busy_r) begin
      if (step_r != 2'd2) begin
        step_nxt = step_r + 2'd1;
      end else if (!q_st.full) begin
        q_push   = 1'b1;
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      step_r <= 2'd0;
    end else begin
      busy_r <= busy_nxt;
      step_r <= step_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      key_r  <= in_thread_key;
      op_r   <= in_operation;
      addr_r <= in_free_address;
      cls_r  <= cls_in;
      tl_r   <= tl_in;
      rem_r  <= 4'd0;
    end else if (busy_r && step_r != 2'd2) begin
      rem_r <= rem_nxt;
    end
  end

  always_comb begin
    q_data.op        = op_r;
    q_data.too_large = tl_r && (op_r == scba_pkg::OP_ALLOC);
    q_data.cls       = cls_r;
    q_data.home      = rem_r[2:0];
    q_data.addr      = addr_r;
  end

endmodule
`default_nettype wire

@@ rtl/scba_queue.sv @@
`default_nettype none
module scba_queue (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 push,
  input  wire scba_pkg::scba_req_t  wr_data,
  input  wire logic                 pop,
  output scba_pkg::scba_req_t       rd_data,
  output scba_pkg::scba_q_st_t      st
);

  scba_pkg::scba_req_t ent_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;

  assign st.full  = cnt_r == 2'd2;
  assign st.empty = cnt_r == 2'd0;
  assign rd_data  = ent_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= !wp_r;
      if (pop)  rp_r <= !rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wp_r] <= wr_data;
    end
  end

endmodule
`default_nettype wire

@@ rtl/scba_back.sv @@
`default_nettype none
module scba_back (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic [scba_pkg::HC_W-1:0]     hc,
  input  wire scba_pkg::scba_q_st_t          q_st,
  input  wire scba_pkg::scba_req_t           q_data,
  output logic                               q_pop,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic [1:0]                         out_status,
  output logic [scba_pkg::ADDR_W-1:0]        out_user_address,
  output logic [scba_pkg::CLS_W-1:0]         out_size_class,
  output logic [scba_pkg::HEAP_W-1:0]        out_heap_index
);

  localparam int PW  = scba_pkg::PAGE_W;
  localparam int BW  = scba_pkg::BLK_W;
  localparam int OW  = scba_pkg::OFF_W;
  localparam int SW  = scba_pkg::SLOT_W;
  localparam int HW  = scba_pkg::HEAP_W;
  localparam int CW  = scba_pkg::CLS_W;
  localparam int AW  = scba_pkg::ADDR_W;
  localparam int TW  = scba_pkg::STRIDE_W;
  localparam int LD  = scba_pkg::LIST_DEPTH;
  localparam int NP  = scba_pkg::PAGE_COUNT;

  scba_pkg::back_state_t state_r, state_nxt;
  scba_pkg::scba_req_t   req_r, req_nxt;

  logic [HW-1:0]   h_r, h_nxt;
  logic [3:0]      i_r, i_nxt;
  logic [SW-1:0]   s_r, s_nxt;
  logic [BW-1:0]   blk_r, blk_nxt;
  logic [CW-1:0]   fcls_r, fcls_nxt;
  logic            bad_r, bad_nxt;
  logic [PW:0]     pages_r, pages_nxt;
  logic [LD-1:0]   hv_r, hv_nxt, cv_r, cv_nxt;
  logic [HW-1:0]   owner_r [NP];
  logic [CW-1:0]   pcls_r  [NP];
  logic            page_we;

  logic [1:0]      res_st_r, res_st_nxt;
  logic [AW-1:0]   res_ua_r, res_ua_nxt;
  logic [CW-1:0]   res_cl_r, res_cl_nxt;
  logic [HW-1:0]   res_hp_r, res_hp_nxt;
  logic            ov_r, ov_nxt;
  logic            out_load;

  logic            head_we, cur_we, link_we;
  logic [SW-1:0]   head_waddr, cur_waddr, list_raddr;
  logic [BW-1:0]   head_wdata, cur_wdata, link_wdata, link_waddr;
  logic [BW-1:0]   head_rdata, cur_rdata, link_rdata;

  logic [SW-1:0]   s_look;
  logic [TW-1:0]   stride;
  logic [OW-1:0]   new_low;
  logic [BW-1:0]   new_blk;
  logic            pool_left, last_heap;
  logic [PW-1:0]   fpage;
  logic [CW-1:0]   fc;
  logic [HW-1:0]   fh;
  logic [AW-1:0]   fmask;
  logic            fbad;
  logic [SW-1:0]   fs;
  logic            free_bad;

  assign s_look    = scba_pkg::slot_of(h_r, req_r.cls);
  assign stride    = TW'(1) << (req_r.cls - 4'd3);
  assign new_low   = OW'((TW'(1) << OW) - stride);
  assign new_blk   = {pages_r[PW-1:0], new_low};
  assign pool_left = pages_r < (PW+1)'(NP);
  assign last_heap = (i_r + 4'd1) == hc;

  assign fpage = req_r.addr[AW-1 -: PW];
  assign fc    = pcls_r[fpage];
  assign fh    = owner_r[fpage];
  assign fmask = (AW'(1) << fc) - AW'(1);
  assign fbad  = ({1'b0, fpage} >= pages_r) || ((req_r.addr & fmask) != AW'(2));
  assign fs    = scba_pkg::slot_of(fh, fc);

  // bad address, already at the head, or not carved yet
  assign free_bad = bad_r
                 || (hv_r[s_r] && head_rdata == blk_r)
                 || (cv_r[s_r] && cur_rdata[BW-1 -: PW] == fpage && blk_r <= cur_rdata);

  assign list_raddr = (state_r == scba_pkg::B_FREE_CHK) ? fs : s_look;
  assign out_load   = (state_r == scba_pkg::B_DONE) && (!ov_r || !out_stall);

  scba_ram #(.WIDTH(BW), .DEPTH(LD)) u_head (
    .clk(clk), .we(head_we), .waddr(head_waddr), .wdata(head_wdata),
    .raddr(list_raddr), .rdata(head_rdata)
  );

  scba_ram #(.WIDTH(BW), .DEPTH(LD)) u_cursor (
    .clk(clk), .we(cur_we), .waddr(cur_waddr), .wdata(cur_wdata),
    .raddr(list_raddr), .rdata(cur_rdata)
  );

  scba_ram #(.WIDTH(BW), .DEPTH(scba_pkg::LINK_DEPTH)) u_link (
    .clk(clk), .we(link_we), .waddr(link_waddr), .wdata(link_wdata),
    .raddr(head_rdata), .rdata(link_rdata)
  );

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      scba_pkg::B_IDLE: begin
        if (!q_st.empty) begin
          if (q_data.too_large)                 state_nxt = scba_pkg::B_DONE;
          else if (q_data.op == scba_pkg::OP_FREE) state_nxt = scba_pkg::B_FREE_CHK;
          else                                  state_nxt = scba_pkg::B_LOOK;
        end
      end
      scba_pkg::B_LOOK: begin
        priority if (hv_r[s_look]) state_nxt = scba_pkg::B_HEAD_RD;
        else if (cv_r[s_look])     state_nxt = scba_pkg::B_CUR;
        else if (pool_left || last_heap) state_nxt = scba_pkg::B_DONE;
        else                       state_nxt = scba_pkg::B_LOOK;
      end
      scba_pkg::B_HEAD_RD:  state_nxt = scba_pkg::B_LINK;
      scba_pkg::B_LINK:     state_nxt = scba_pkg::B_DONE;
      scba_pkg::B_CUR:      state_nxt = scba_pkg::B_DONE;
      scba_pkg::B_FREE_CHK: state_nxt = scba_pkg::B_FREE_RD;
      scba_pkg::B_FREE_RD:  state_nxt = scba_pkg::B_DONE;
      scba_pkg::B_DONE: begin
        if (out_load) state_nxt = scba_pkg::B_IDLE;
      end
      default: state_nxt = scba_pkg::B_IDLE;
    endcase
  end

  always_comb begin
    req_nxt    = req_r;
    h_nxt      = h_r;
    i_nxt      = i_r;
    s_nxt      = s_r;
    blk_nxt    = blk_r;
    fcls_nxt   = fcls_r;
    bad_nxt    = bad_r;
    pages_nxt  = pages_r;
    hv_nxt     = hv_r;
    cv_nxt     = cv_r;
    page_we    = 1'b0;
    res_st_nxt = res_st_r;
    res_ua_nxt = res_ua_r;
    res_cl_nxt = res_cl_r;
    res_hp_nxt = res_hp_r;
    ov_nxt     = ov_r && out_stall;
    q_pop      = 1'b0;
    head_we    = 1'b0;
    head_waddr = s_r;
    head_wdata = link_rdata;
    cur_we     = 1'b0;
    cur_waddr  = s_r;
    cur_wdata  = cur_rdata - BW'(stride);
    link_we    = 1'b0;
    link_waddr = blk_r;
    link_wdata = blk_r;
    unique case (state_r)
      scba_pkg::B_IDLE: begin
        if (!q_st.empty) begin
          q_pop      = 1'b1;
          req_nxt    = q_data;
          h_nxt      = q_data.home;
          i_nxt      = 4'd0;
          res_st_nxt = scba_pkg::ST_TOO_LARGE;
          res_ua_nxt = '0;
          res_cl_nxt = '0;
          res_hp_nxt = '0;
        end
      end
      scba_pkg::B_LOOK: begin
        s_nxt      = s_look;
        res_st_nxt = scba_pkg::ST_OK;
        res_cl_nxt = req_r.cls;
        res_hp_nxt = h_r;
        priority if (hv_r[s_look] || cv_r[s_look]) begin
        end else if (pool_left) begin
          // fresh page, top block handed out at once
          page_we    = 1'b1;
          pages_nxt  = pages_r + (PW+1)'(1);
          res_ua_nxt = {new_blk, 3'b010};
          if (new_low != '0) begin
            cur_we         = 1'b1;
            cur_waddr      = s_look;
            cur_wdata      = new_blk - BW'(stride);
            cv_nxt[s_look] = 1'b1;
          end
        end else if (last_heap) begin
          res_st_nxt = scba_pkg::ST_NO_MEM;
          res_ua_nxt = '0;
          res_hp_nxt = req_r.home;
        end else begin
          h_nxt = (({1'b0, h_r} + 4'd1) == hc) ? '0 : h_r + HW'(1);
          i_nxt = i_r + 4'd1;
        end
      end
      scba_pkg::B_HEAD_RD: begin
        blk_nxt = head_rdata;
      end
      scba_pkg::B_LINK: begin
        res_ua_nxt = {blk_r, 3'b010};
        if (link_rdata == blk_r) hv_nxt[s_r] = 1'b0;
        else                     head_we     = 1'b1;
      end
      scba_pkg::B_CUR: begin
        res_ua_nxt = {cur_rdata, 3'b010};
        if (cur_rdata[OW-1:0] == '0) cv_nxt[s_r] = 1'b0;
        else                         cur_we      = 1'b1;
      end
      scba_pkg::B_FREE_CHK: begin
        bad_nxt  = fbad;
        fcls_nxt = fc;
        h_nxt    = fh;
        blk_nxt  = req_r.addr[AW-1:3];
        s_nxt    = fs;
      end
      scba_pkg::B_FREE_RD: begin
        res_ua_nxt = '0;
        if (free_bad) begin
          res_st_nxt = scba_pkg::ST_BAD_FREE;
          res_cl_nxt = '0;
          res_hp_nxt = '0;
        end else begin
          res_st_nxt  = scba_pkg::ST_OK;
          res_cl_nxt  = fcls_r;
          res_hp_nxt  = h_r;
          link_we     = 1'b1;
          link_wdata  = hv_r[s_r] ? head_rdata : blk_r;
          head_we     = 1'b1;
          head_wdata  = blk_r;
          hv_nxt[s_r] = 1'b1;
        end
      end
      scba_pkg::B_DONE: begin
        if (out_load) ov_nxt = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= scba_pkg::B_IDLE;
      pages_r <= '0;
      hv_r    <= '0;
      cv_r    <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      pages_r <= pages_nxt;
      hv_r    <= hv_nxt;
      cv_r    <= cv_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r    <= req_nxt;
    h_r      <= h_nxt;
    i_r      <= i_nxt;
    s_r      <= s_nxt;
    blk_r    <= blk_nxt;
    fcls_r   <= fcls_nxt;
    bad_r    <= bad_nxt;
    res_st_r <= res_st_nxt;
    res_ua_r <= res_ua_nxt;
    res_cl_r <= res_cl_nxt;
    res_hp_r <= res_hp_nxt;
    if (page_we) begin
      owner_r[pages_r[PW-1:0]] <= h_r;
      pcls_r[pages_r[PW-1:0]]  <= req_r.cls;
    end
    if (out_load) begin
      out_status       <= res_st_r;
      out_user_address <= res_ua_r;
      out_size_class   <= res_cl_r;
      out_heap_index   <= res_hp_r;
    end
  end

  assign out_valid = ov_r;

endmodule
`default_nettype wire

@@ rtl/size_class_block_allocator_top.sv @@
`default_nettype none
// Request path: the front computes the size class and the key modulo heap_count and
// pushes the request into a two-entry queue; the back then handles a too_large word, a
// fresh page, a carved block, a free, a pop from a free list, or out of memory.
// The front takes a new word only when idle and stalls while busy; through the queue it can
// take the next word while the back still does the list-head and link RAM read-modify-write.
// An out-of-memory walk holds the back while it tries each heap in turn.
// Reset (rst_n low, synchronous): heap_count 4, pool empty, all lists empty.
module size_class_block_allocator_top (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic                        in_operation,
  input  wire logic [15:0]                 in_thread_key,
  input  wire logic [15:0]                 in_request_bytes,
  input  wire logic [scba_pkg::ADDR_W-1:0] in_free_address,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic [1:0]                       out_status,
  output logic [scba_pkg::ADDR_W-1:0]      out_user_address,
  output logic [scba_pkg::CLS_W-1:0]       out_size_class,
  output logic [scba_pkg::HEAP_W-1:0]      out_heap_index,
  input  wire logic                        cfg_we,
  input  wire logic [scba_pkg::HC_W-1:0]   cfg_wdata
);

  logic [scba_pkg::HC_W-1:0] hc_r, hc_eff;
  scba_pkg::scba_req_t       push_data, pop_data;
  scba_pkg::scba_q_st_t      q_st;
  logic                      q_push, q_pop;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hc_r <= scba_pkg::HC_RESET;
    end else if (cfg_we) begin
      hc_r <= cfg_wdata;
    end
  end

  assign hc_eff = scba_pkg::hc_clamp(hc_r);

  scba_front u_front (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .in_operation(in_operation), .in_thread_key(in_thread_key),
    .in_request_bytes(in_request_bytes), .in_free_address(in_free_address),
    .hc(hc_eff), .q_st(q_st), .q_push(q_push), .q_data(push_data)
  );

  scba_queue u_queue (
    .clk(clk), .rst_n(rst_n), .push(q_push), .wr_data(push_data),
    .pop(q_pop), .rd_data(pop_data), .st(q_st)
  );

  scba_back u_back (
    .clk(clk), .rst_n(rst_n), .hc(hc_eff), .q_st(q_st), .q_data(pop_data),
    .q_pop(q_pop), .out_valid(out_valid), .out_stall(out_stall),
    .out_status(out_status), .out_user_address(out_user_address),
    .out_size_class(out_size_class), .out_heap_index(out_heap_index)
  );

`ifndef NO_ASSERTIONS
  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_st.full) else $error("queue push while full");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_st.empty) else $error("queue pop while empty");
  a_tl_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == scba_pkg::ST_TOO_LARGE) |->
      (out_user_address == '0 && out_heap_index == '0))
    else $error("too_large word carries data");
  a_ok_class: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == scba_pkg::ST_OK) |-> (out_size_class >= 4'd3))
    else $error("ok word with class below minimum");
`endif

endmodule
`default_nettype wire
